FILE: rtl/ckb_pkg.sv
// Shared types and constants for the color-keyed sprite blitter.
package ckb_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 320;
   localparam int SCREEN_HEIGHT_DEFAULT = 240;

   localparam int POS_W     = 10;
   localparam int SIZE_W    = 8;
   localparam int PIXEL_W   = 8;
   localparam int ADDR_W    = 17;
   localparam int COORD_W   = 12;
   localparam int SCREEN_W  = 11;
   localparam int PROD_W    = POS_W + SCREEN_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   localparam logic [CSR_IDX_W-1:0] REG_DEST_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIRROR_ENABLE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_COLOR     = 3'd5;

   typedef struct packed {
      logic signed [POS_W-1:0] dest_x;
      logic signed [POS_W-1:0] dest_y;
      logic [SIZE_W-1:0]       sprite_width;
      logic [SIZE_W-1:0]       sprite_height;
      logic                    mirror_enable;
      logic [PIXEL_W-1:0]      key_color;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [SIZE_W-1:0]  column;
      logic [SIZE_W-1:0]  row;
   } src_word_type;

   typedef struct packed {
      logic out_free;
      logic emit;
   } place_status_type;

endpackage

FILE: rtl/ckb_csr.sv
// Configuration register file of the sprite blitter.
module ckb_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ckb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ckb_pkg::CSR_DAT_W-1:0]  csr_data,
   output ckb_pkg::cfg_type               cfg
);
   import ckb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DEST_X:        cfg_in.dest_x        = csr_data[POS_W-1:0];
            REG_DEST_Y:        cfg_in.dest_y        = csr_data[POS_W-1:0];
            REG_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_data[SIZE_W-1:0];
            REG_SPRITE_HEIGHT: cfg_in.sprite_height = csr_data[SIZE_W-1:0];
            REG_MIRROR_ENABLE: cfg_in.mirror_enable = csr_data[0];
            REG_KEY_COLOR:     cfg_in.key_color     = csr_data[PIXEL_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x        <= '0;
         cfg_ff.dest_y        <= '0;
         cfg_ff.sprite_width  <= SIZE_W'(1);
         cfg_ff.sprite_height <= SIZE_W'(1);
         cfg_ff.mirror_enable <= 1'b0;
         cfg_ff.key_color     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/ckb_count.sv
// Source column and row counters with the input word register.
module ckb_count (
   input  logic                        clock,
   input  logic                        reset,
   input  ckb_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ckb_pkg::PIXEL_W-1:0] req_source_pixel,
   input  logic                        advance,
   output logic                        src_valid,
   output ckb_pkg::src_word_type       src_word
);
   import ckb_pkg::*;

   logic [SIZE_W-1:0] column_count_ff, column_count_in;
   logic [SIZE_W-1:0] row_count_ff, row_count_in;
   logic              src_valid_ff, src_valid_in;
   src_word_type      src_word_ff, src_word_in;
   logic              load;
   logic              accept;
   logic              size_zero;
   logic [SIZE_W:0]   column_next;
   logic [SIZE_W:0]   row_next;

   assign load      = !src_valid_ff || advance;
   assign req_stall = !load;
   assign accept    = req_valid && load;
   assign src_valid = src_valid_ff;
   assign src_word  = src_word_ff;

   assign size_zero   = (cfg.sprite_width == '0) || (cfg.sprite_height == '0);
   assign column_next = {1'b0, column_count_ff} + (SIZE_W + 1)'(1);
   assign row_next    = {1'b0, row_count_ff} + (SIZE_W + 1)'(1);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (size_zero) begin
            column_count_in = '0;
            row_count_in    = '0;
         end else if (column_next >= {1'b0, cfg.sprite_width}) begin
            column_count_in = '0;
            if (row_next >= {1'b0, cfg.sprite_height}) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_next[SIZE_W-1:0];
            end
         end else begin
            column_count_in = column_next[SIZE_W-1:0];
         end
      end
   end

   always_comb begin
      src_valid_in = load ? req_valid : src_valid_ff;
      src_word_in  = src_word_ff;
      if (accept) begin
         src_word_in.pixel  = req_source_pixel;
         src_word_in.column = column_count_ff;
         src_word_in.row    = row_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         src_valid_ff    <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         src_valid_ff    <= src_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_word_ff <= src_word_in;
   end

endmodule

FILE: rtl/ckb_place.sv
// Mirroring, clipping, color keying and address generation with the result register.
module ckb_place #(
   parameter int SCREEN_WIDTH  = ckb_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = ckb_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ckb_pkg::cfg_type            cfg,
   input  logic                        src_valid,
   input  ckb_pkg::src_word_type       src_word,
   output ckb_pkg::place_status_type   status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ckb_pkg::ADDR_W-1:0]  rsp_write_address,
   output logic [ckb_pkg::PIXEL_W-1:0] rsp_write_pixel
);
   import ckb_pkg::*;

   localparam logic [SCREEN_W-1:0] SCR_W = SCREEN_W'(SCREEN_WIDTH);
   localparam logic [SCREEN_W-1:0] SCR_H = SCREEN_W'(SCREEN_HEIGHT);

   logic signed [COORD_W-1:0] col;
   logic signed [COORD_W-1:0] sx;
   logic signed [COORD_W-1:0] sy;
   logic                      on_screen;
   logic                      emit;
   logic                      out_free;
   logic [PROD_W-1:0]         product;
   logic [PROD_W-1:0]         address;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]         rsp_write_address_ff, rsp_write_address_in;
   logic [PIXEL_W-1:0]        rsp_write_pixel_ff, rsp_write_pixel_in;

   always_comb begin
      if (cfg.mirror_enable) begin
         col = $signed({{(COORD_W - SIZE_W){1'b0}}, cfg.sprite_width})
             - COORD_W'(1)
             - $signed({{(COORD_W - SIZE_W){1'b0}}, src_word.column});
      end else begin
         col = $signed({{(COORD_W - SIZE_W){1'b0}}, src_word.column});
      end
   end

   assign sx = $signed({{(COORD_W - POS_W){cfg.dest_x[POS_W-1]}}, cfg.dest_x}) + col;
   assign sy = $signed({{(COORD_W - POS_W){cfg.dest_y[POS_W-1]}}, cfg.dest_y})
             + $signed({{(COORD_W - SIZE_W){1'b0}}, src_word.row});

   assign on_screen = !sx[COORD_W-1] && (sx[SCREEN_W-1:0] < SCR_W)
                   && !sy[COORD_W-1] && (sy[SCREEN_W-1:0] < SCR_H);

   assign emit = (cfg.sprite_width != '0) && (cfg.sprite_height != '0)
              && on_screen && (src_word.pixel != cfg.key_color);

   assign product = PROD_W'(sy[POS_W-1:0]) * PROD_W'(SCR_W);
   assign address = product + PROD_W'(sx[POS_W-1:0]);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.out_free = out_free;
   assign status.emit     = emit;

   always_comb begin
      rsp_valid_in         = rsp_valid_ff;
      rsp_write_address_in = rsp_write_address_ff;
      rsp_write_pixel_in   = rsp_write_pixel_ff;
      if (out_free) begin
         rsp_valid_in         = src_valid && emit;
         rsp_write_address_in = address[ADDR_W-1:0];
         rsp_write_pixel_in   = src_word.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_write_address_ff <= rsp_write_address_in;
      rsp_write_pixel_ff   <= rsp_write_pixel_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_write_address_ff;
   assign rsp_write_pixel   = rsp_write_pixel_ff;

endmodule

FILE: rtl/color_key_sprite_blitter_unit.sv
// Top level of the color-keyed, clipped sprite blitter.
// An accepted word passes through the input register and then the result register before its write shows on rsp.
// One pixel word per cycle while rsp_stall does not hold the result register, set by the input and result registers.
// Clipped and transparent pixels leave the pipeline without producing a write.
// Reset is synchronous: counters go to zero, width and height to one, other settings and valid flags to zero.
module color_key_sprite_blitter_unit #(
   parameter int SCREEN_WIDTH  = ckb_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = ckb_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ckb_pkg::PIXEL_W-1:0]   req_source_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ckb_pkg::ADDR_W-1:0]    rsp_write_address,
   output logic [ckb_pkg::PIXEL_W-1:0]   rsp_write_pixel,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ckb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ckb_pkg::CSR_DAT_W-1:0] csr_data
);
   import ckb_pkg::*;

   cfg_type          cfg;
   src_word_type     src_word;
   logic             src_valid;
   place_status_type status;

   ckb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ckb_count u_count (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_pixel (req_source_pixel),
      .advance          (status.out_free),
      .src_valid        (src_valid),
      .src_word         (src_word)
   );

   ckb_place #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_place (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .src_valid         (src_valid),
      .src_word          (src_word),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_pixel   (rsp_write_pixel)
   );

   // The input side stalls only while a word waits behind a blocked result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (src_valid && !status.out_free))
      else $error("input stalled without a blocked word");

   // An accepted word is held in the input register on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> src_valid)
      else $error("accepted word was lost");

   // A word that draws and finds the result register free becomes a write.
   assert property (@(posedge clock) disable iff (reset)
      (src_valid && status.emit && status.out_free) |=> rsp_valid)
      else $error("drawn pixel produced no write");

endmodule
